@@ rtl/pwmc_pkg.sv @@
// ----------------------------------------------------------------------------
// pwmc_pkg
// Types, codes and helpers shared by the power-window mode controller.
// ----------------------------------------------------------------------------
package pwmc_pkg;

  localparam int InDataW  = 24;
  localparam int OutDataW = 16;

  typedef enum logic [4:0] {
    MODE_VERIFY     = 5'b00001,
    MODE_MANUAL     = 5'b00010,
    MODE_AUTO_OPEN  = 5'b00100,
    MODE_AUTO_CLOSE = 5'b01000,
    MODE_NO_DEVICE  = 5'b10000
  } mode_t;

  localparam logic [2:0] CODE_VERIFY     = 3'd0;
  localparam logic [2:0] CODE_MANUAL     = 3'd1;
  localparam logic [2:0] CODE_AUTO_OPEN  = 3'd2;
  localparam logic [2:0] CODE_AUTO_CLOSE = 3'd3;
  localparam logic [2:0] CODE_NO_DEVICE  = 3'd4;

  localparam logic [1:0] MOTOR_STOP = 2'd0;
  localparam logic [1:0] MOTOR_DOWN = 2'd1;
  localparam logic [1:0] MOTOR_UP   = 2'd2;

  localparam logic [1:0] REQ_SHORT = 2'd1;
  localparam logic [1:0] REQ_LONG  = 2'd2;
  localparam logic [1:0] REQ_STUCK = 2'd3;

  localparam logic [1:0] END_OPEN   = 2'd1;
  localparam logic [1:0] END_CLOSED = 2'd2;

  localparam logic [7:0] DEVICE_PRESENT_ID = 8'h00;

  typedef struct packed {
    logic       pinch_sensor;
    logic [1:0] end_status;
    logic [1:0] down_request;
    logic [1:0] up_request;
    logic       down_button;
    logic       up_button;
    logic       lock_switch;
    logic [7:0] device_id_code;
  } item_t;

  typedef struct packed {
    mode_t      mode;
    logic       reversal;
    logic [1:0] motor;
    logic [1:0] position;
    logic       lock;
  } ctrl_state_t;

  typedef struct packed {
    logic       clear_down_request;
    logic       clear_up_request;
    logic       lock_indication;
    logic [1:0] position_echo;
    logic [1:0] motor_command;
    logic [2:0] mode;
  } result_t;

  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] c;
    c = CODE_VERIFY;
    case (m)
      MODE_VERIFY:     c = CODE_VERIFY;
      MODE_MANUAL:     c = CODE_MANUAL;
      MODE_AUTO_OPEN:  c = CODE_AUTO_OPEN;
      MODE_AUTO_CLOSE: c = CODE_AUTO_CLOSE;
      MODE_NO_DEVICE:  c = CODE_NO_DEVICE;
      default:         c = CODE_VERIFY;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/pwmc_next.sv @@
// ----------------------------------------------------------------------------
// pwmc_next
// Next-state and result decision for one control tick.
// ----------------------------------------------------------------------------
module pwmc_next (
  input  pwmc_pkg::ctrl_state_t cur,
  input  pwmc_pkg::item_t       item,
  output pwmc_pkg::ctrl_state_t nxt,
  output pwmc_pkg::result_t     res
);

  logic       up;
  logic       dn;
  logic [1:0] st;
  logic       clr_up;
  logic       clr_dn;

  assign up = item.up_button;
  assign dn = item.down_button;
  assign st = item.end_status;

  always_comb begin
    nxt    = cur;
    clr_up = 1'b0;
    clr_dn = 1'b0;
    case (cur.mode)
      pwmc_pkg::MODE_VERIFY: begin
        nxt.mode = (item.device_id_code == pwmc_pkg::DEVICE_PRESENT_ID) ?
                   pwmc_pkg::MODE_MANUAL : pwmc_pkg::MODE_NO_DEVICE;
      end
      pwmc_pkg::MODE_MANUAL: begin
        if (item.lock_switch) begin
          nxt.motor    = pwmc_pkg::MOTOR_STOP;
          nxt.position = st;
          nxt.lock     = 1'b1;
          clr_up       = 1'b1;
          clr_dn       = 1'b1;
        end else begin
          if (up == dn) begin
            nxt.motor    = pwmc_pkg::MOTOR_STOP;
            nxt.position = st;
          end
          if (!up && !dn && item.down_request == pwmc_pkg::REQ_SHORT &&
              st != pwmc_pkg::END_OPEN) begin
            nxt.mode = pwmc_pkg::MODE_AUTO_OPEN;
            clr_dn   = 1'b1;
          end else if (item.up_request == pwmc_pkg::REQ_SHORT && !up && !dn &&
                       st != pwmc_pkg::END_CLOSED) begin
            nxt.mode = pwmc_pkg::MODE_AUTO_CLOSE;
            clr_up   = 1'b1;
          end else if (item.up_request == pwmc_pkg::REQ_LONG && up && !dn &&
                       st != pwmc_pkg::END_CLOSED) begin
            nxt.motor    = pwmc_pkg::MOTOR_UP;
            nxt.position = st;
            clr_up       = 1'b1;
          end else if (!up && item.down_request == pwmc_pkg::REQ_LONG && dn &&
                       st != pwmc_pkg::END_OPEN) begin
            nxt.motor    = pwmc_pkg::MOTOR_DOWN;
            nxt.position = st;
            clr_dn       = 1'b1;
          end
        end
      end
      pwmc_pkg::MODE_AUTO_OPEN: begin
        nxt.position = st;
        if (item.lock_switch) begin
          nxt.motor = pwmc_pkg::MOTOR_STOP;
          nxt.lock  = 1'b1;
          nxt.mode  = pwmc_pkg::MODE_MANUAL;
        end else if (st != pwmc_pkg::END_OPEN) begin
          nxt.lock = 1'b0;
          if (item.pinch_sensor || cur.reversal) begin
            nxt.motor = pwmc_pkg::MOTOR_DOWN;
            clr_up    = 1'b1;
          end else if (item.up_request == pwmc_pkg::REQ_SHORT && !up && !dn) begin
            nxt.motor = pwmc_pkg::MOTOR_UP;
            clr_dn    = 1'b1;
            nxt.mode  = pwmc_pkg::MODE_AUTO_CLOSE;
          end else if (item.up_request == pwmc_pkg::REQ_LONG && !dn && up) begin
            nxt.motor = pwmc_pkg::MOTOR_UP;
            clr_dn    = 1'b1;
            nxt.mode  = pwmc_pkg::MODE_MANUAL;
          end else if ((up && dn) || item.up_request == pwmc_pkg::REQ_STUCK) begin
            nxt.motor = pwmc_pkg::MOTOR_STOP;
            clr_dn    = 1'b1;
            nxt.mode  = pwmc_pkg::MODE_MANUAL;
          end else begin
            nxt.motor = pwmc_pkg::MOTOR_DOWN;
          end
        end else begin
          nxt.motor    = pwmc_pkg::MOTOR_STOP;
          clr_dn       = 1'b1;
          nxt.lock     = 1'b0;
          nxt.mode     = pwmc_pkg::MODE_MANUAL;
          nxt.reversal = 1'b0;
        end
      end
      pwmc_pkg::MODE_AUTO_CLOSE: begin
        nxt.position = st;
        if (item.lock_switch) begin
          nxt.motor = pwmc_pkg::MOTOR_STOP;
          nxt.lock  = 1'b1;
          nxt.mode  = pwmc_pkg::MODE_MANUAL;
        end else if (st != pwmc_pkg::END_CLOSED) begin
          nxt.lock = 1'b0;
          if (item.pinch_sensor) begin
            nxt.motor    = pwmc_pkg::MOTOR_STOP;
            clr_up       = 1'b1;
            nxt.mode     = pwmc_pkg::MODE_AUTO_OPEN;
            nxt.reversal = 1'b1;
          end else if (item.down_request == pwmc_pkg::REQ_SHORT && !up && !dn) begin
            nxt.motor = pwmc_pkg::MOTOR_DOWN;
            clr_up    = 1'b1;
            nxt.mode  = pwmc_pkg::MODE_AUTO_OPEN;
          end else if (item.down_request == pwmc_pkg::REQ_LONG && !up && dn) begin
            nxt.motor = pwmc_pkg::MOTOR_DOWN;
            clr_up    = 1'b1;
            nxt.mode  = pwmc_pkg::MODE_MANUAL;
          end else if ((up && dn) || item.up_request == pwmc_pkg::REQ_STUCK) begin
            nxt.motor = pwmc_pkg::MOTOR_STOP;
            nxt.mode  = pwmc_pkg::MODE_MANUAL;
          end else begin
            nxt.motor = pwmc_pkg::MOTOR_UP;
            clr_up    = 1'b1;
          end
        end else begin
          nxt.motor = pwmc_pkg::MOTOR_STOP;
          clr_up    = 1'b1;
          nxt.lock  = 1'b0;
          nxt.mode  = pwmc_pkg::MODE_MANUAL;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  always_comb begin
    res.mode               = pwmc_pkg::mode_code(nxt.mode);
    res.motor_command      = nxt.motor;
    res.position_echo      = nxt.position;
    res.lock_indication    = nxt.lock;
    res.clear_up_request   = clr_up;
    res.clear_down_request = clr_dn;
  end

endmodule

@@ rtl/power_window_mode_controller.sv @@
// ----------------------------------------------------------------------------
// power_window_mode_controller
// Power-window mode machine: device check, manual drive, auto open/close
// with anti-pinch reversal, one decision per control tick.
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+--------------------------------------
//   in_     | in  | in_tvalid/tready  | in_tdata  24 bits, one tick's inputs
//   out_    | out | out_tvalid/tready | out_tdata 16 bits, one tick's result
//
// one beat per clock sustained while out_tready is high; an input register, then a result
// register with the decision logic between them
// rst_n clears the mode to verify, motor to stop, position, lock and reversal
// a stalled result holds its register; the input register still takes a beat,
// and input stalls only when both registers are full
// ----------------------------------------------------------------------------
module power_window_mode_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // device_id_code[7:0], lock_switch[8], up_button[9], down_button[10],
  // up_request[12:11], down_request[14:13], end_status[16:15],
  // pinch_sensor[17], zero[23:18]
  input  logic [pwmc_pkg::InDataW-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // mode[2:0], motor_command[4:3], position_echo[6:5], lock_indication[7],
  // clear_up_request[8], clear_down_request[9], zero[15:10]
  output logic [pwmc_pkg::OutDataW-1:0] out_tdata
);

  logic                  in_valid_r;
  pwmc_pkg::item_t       in_item_r;
  logic                  out_valid_r;
  pwmc_pkg::result_t     out_res_r;
  pwmc_pkg::ctrl_state_t state_r;
  pwmc_pkg::ctrl_state_t state_nxt;
  pwmc_pkg::result_t     res_nxt;
  logic                  out_load;
  logic                  fire;

  assign out_load  = !out_valid_r || out_tready;
  assign fire      = in_valid_r && out_load;
  assign in_tready = !in_valid_r || out_load;

  pwmc_next u_next (
    .cur  (state_r),
    .item (in_item_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{mode: pwmc_pkg::MODE_VERIFY, reversal: 1'b0,
                       motor: pwmc_pkg::MOTOR_STOP, position: 2'd0, lock: 1'b0};
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (out_load) begin
        out_valid_r <= in_valid_r;
      end
      if (fire) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= pwmc_pkg::item_t'(in_tdata[$bits(pwmc_pkg::item_t)-1:0]);
    end
    if (fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(pwmc_pkg::OutDataW - $bits(pwmc_pkg::result_t)){1'b0}},
                       out_res_r};

  a_no_device_terminal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.mode == pwmc_pkg::MODE_NO_DEVICE |=> state_r.mode == pwmc_pkg::MODE_NO_DEVICE)
    else $error("no-device mode left");

  a_reversal_into_open: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r.reversal) |-> state_r.mode == pwmc_pkg::MODE_AUTO_OPEN)
    else $error("reversal flag set outside auto open");

  a_double_clear_locked: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res_r.clear_up_request && out_res_r.clear_down_request
      |-> out_res_r.lock_indication)
    else $error("both latches cleared without lock");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(state_r))
    else $error("state moved while result stalled");

endmodule
